### src/ssm_pkg.sv
// Shared types, constants and register map of the speech segment merger.
`default_nettype none
package ssm_pkg;

    // Width of all millisecond times inside the block.
    localparam int TIME_BITS = 32;
    // Width of the time fields on the result channel.
    localparam int OUT_BITS  = 32;
    localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 64'd1;

    typedef logic [TIME_BITS-1:0] t_time;

    // 0.15 in Q0.16, rounded to nearest.
    localparam logic [15:0] LOW_OFFSET = 16'd9830;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int ADDR_BITS = 5;
    localparam int CNT_BITS  = 24;
    // Width of the window count times window length product.
    localparam int PROD_BITS = CNT_BITS + 10;

    localparam logic [2:0] REG_THRESHOLD     = 3'd0;
    localparam logic [2:0] REG_WINDOW_MS     = 3'd1;
    localparam logic [2:0] REG_MIN_SILENCE   = 3'd2;
    localparam logic [2:0] REG_MIN_SPEECH    = 3'd3;
    localparam logic [2:0] REG_SPEECH_PAD    = 3'd4;
    localparam logic [2:0] REG_TOTAL_WINDOWS = 3'd5;

    localparam logic [15:0] RST_THRESHOLD     = 16'd32768;
    localparam logic [9:0]  RST_WINDOW_MS     = 10'd32;
    localparam logic [15:0] RST_MIN_SILENCE   = 16'd100;
    localparam logic [15:0] RST_MIN_SPEECH    = 16'd250;
    localparam logic [15:0] RST_SPEECH_PAD    = 16'd30;
    localparam logic [23:0] RST_TOTAL_WINDOWS = 24'd65535;

    typedef struct packed {
        logic [15:0]         threshold;
        logic [9:0]          window_ms;
        logic [15:0]         min_silence_ms;
        logic [15:0]         min_speech_ms;
        logic [15:0]         speech_pad_ms;
        logic [CNT_BITS-1:0] total_windows;
    } t_cfg;

    // Classification of one window as seen by the segment tracker.
    typedef struct packed {
        logic loud;
        logic near;
    } t_class;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            empty;
        logic            full;
    } t_qstat;

endpackage
`default_nettype wire

### src/ssm_regs.sv
// Configuration register bank with its APB-style access port.
`default_nettype none
module ssm_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssm_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output ssm_pkg::t_cfg                      o_cfg
);
    import ssm_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold      <= RST_THRESHOLD;
            r_cfg.window_ms      <= RST_WINDOW_MS;
            r_cfg.min_silence_ms <= RST_MIN_SILENCE;
            r_cfg.min_speech_ms  <= RST_MIN_SPEECH;
            r_cfg.speech_pad_ms  <= RST_SPEECH_PAD;
            r_cfg.total_windows  <= RST_TOTAL_WINDOWS;
        end else if (wr) begin
            unique case (idx)
                REG_THRESHOLD:     r_cfg.threshold      <= pwdata[15:0];
                REG_WINDOW_MS:     r_cfg.window_ms      <= pwdata[9:0];
                REG_MIN_SILENCE:   r_cfg.min_silence_ms <= pwdata[15:0];
                REG_MIN_SPEECH:    r_cfg.min_speech_ms  <= pwdata[15:0];
                REG_SPEECH_PAD:    r_cfg.speech_pad_ms  <= pwdata[15:0];
                REG_TOTAL_WINDOWS: r_cfg.total_windows  <= pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD:     prdata = {16'd0, r_cfg.threshold};
            REG_WINDOW_MS:     prdata = {22'd0, r_cfg.window_ms};
            REG_MIN_SILENCE:   prdata = {16'd0, r_cfg.min_silence_ms};
            REG_MIN_SPEECH:    prdata = {16'd0, r_cfg.min_speech_ms};
            REG_SPEECH_PAD:    prdata = {16'd0, r_cfg.speech_pad_ms};
            REG_TOTAL_WINDOWS: prdata = {8'd0, r_cfg.total_windows};
            default:           prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

### src/ssm_front.sv
// Input side: accepts windows and classifies them against both thresholds.
`default_nettype none
module ssm_front (
    input  wire logic            i_in_valid,
    input  wire logic [15:0]     i_prob,
    input  wire logic            i_failed,
    input  ssm_pkg::t_cfg        i_cfg,
    input  ssm_pkg::t_qstat      i_qstat,
    output logic                 o_in_stall,
    output logic                 o_push,
    output ssm_pkg::t_class      o_item
);
    import ssm_pkg::*;

    logic low_neg;

    // Below the offset the lower threshold is negative, so any good window qualifies.
    assign low_neg     = i_cfg.threshold < LOW_OFFSET;
    assign o_item.loud = !i_failed && (i_prob >= i_cfg.threshold);
    assign o_item.near = !i_failed && (low_neg || (i_prob >= i_cfg.threshold - LOW_OFFSET));

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

endmodule
`default_nettype wire

### src/ssm_queue.sv
// Short queue of classified windows between the front and the tracker.
`default_nettype none
module ssm_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  ssm_pkg::t_class  i_item,
    input  wire logic        i_pop,
    output ssm_pkg::t_class  o_item,
    output ssm_pkg::t_qstat  o_stat
);
    import ssm_pkg::*;

    t_class          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == Q_CW'(Q_DEPTH));

endmodule
`default_nettype wire

### src/ssm_back.sv
// Segment tracker: hysteresis state, segment timing and the result register.
`default_nettype none
module ssm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  ssm_pkg::t_cfg                     i_cfg,
    input  ssm_pkg::t_class                   i_item,
    input  ssm_pkg::t_qstat                   i_qstat,
    input  wire logic                         i_out_stall,
    output logic                              o_pop,
    output logic                              o_out_valid,
    output logic [ssm_pkg::OUT_BITS-1:0]      o_seg_start_ms,
    output logic [ssm_pkg::OUT_BITS-1:0]      o_seg_end_ms
);
    import ssm_pkg::*;

    function automatic t_time sat_add(input t_time a, input logic [15:0] b);
        logic [TIME_BITS:0] sum;
        sum = {1'b0, a} + (TIME_BITS + 1)'(b);
        return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    endfunction

    function automatic t_time tdiff(input t_time a, input t_time b);
        return (a > b) ? a - b : '0;
    endfunction

    logic                r_trig;
    logic                r_pend;
    t_time               r_sil;
    t_time               r_seg;
    t_time               r_clock;
    logic [CNT_BITS-1:0] r_cnt;
    t_time               r_stream_end;
    logic                r_ovalid;
    t_time               r_ostart;
    t_time               r_oend;

    logic                n_trig;
    logic                n_pend;
    t_time               n_sil;
    t_time               n_seg;
    t_time               n_clock;
    logic [CNT_BITS-1:0] n_cnt;

    logic [PROD_BITS-1:0] prod;
    t_time               stream_end_c;
    t_time               win_end;
    t_time               sil;
    t_time               pad_end;
    t_time               min_sil;
    t_time               min_sp;
    t_time               pad;
    logic                emit;
    t_time               e_start;
    t_time               e_end;

    // The stream end only changes with configuration, so it is kept registered.
    assign prod         = PROD_BITS'(i_cfg.total_windows) * PROD_BITS'(i_cfg.window_ms);
    assign stream_end_c = (64'(prod) > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : TIME_BITS'(prod);

    assign min_sil = TIME_BITS'(i_cfg.min_silence_ms);
    assign min_sp  = TIME_BITS'(i_cfg.min_speech_ms);
    assign pad     = TIME_BITS'(i_cfg.speech_pad_ms);

    assign o_pop = !i_qstat.empty && (!r_ovalid || !i_out_stall);

    always_comb begin
        win_end = sat_add(r_clock, {6'd0, i_cfg.window_ms});
        n_trig  = r_trig;
        n_pend  = r_pend;
        n_sil   = r_sil;
        n_seg   = r_seg;
        n_clock = r_clock;
        n_cnt   = r_cnt;
        sil     = r_pend ? r_sil : r_clock;
        pad_end = sat_add(sil, i_cfg.speech_pad_ms);
        emit    = 1'b0;
        e_start = '0;
        e_end   = '0;
        if (o_pop) begin
            if (i_item.loud) begin
                n_pend = 1'b0;
            end
            if (i_item.near && !r_trig) begin
                n_trig = 1'b1;
                n_seg  = r_clock;
            end else if (!i_item.loud && r_trig) begin
                n_pend = 1'b1;
                n_sil  = sil;
                if (tdiff(win_end, sil) >= min_sil) begin
                    if (tdiff(sil, r_seg) > min_sp) begin
                        emit    = 1'b1;
                        e_start = (r_seg > pad) ? r_seg - pad : '0;
                        e_end   = (pad_end > r_stream_end) ? r_stream_end : pad_end;
                    end
                    n_trig = 1'b0;
                    n_pend = 1'b0;
                    n_sil  = '0;
                    n_seg  = '0;
                end
            end
            n_clock = win_end;
            n_cnt   = r_cnt + CNT_BITS'(1);
            // Last window of the stream: flush an open segment unpadded and start over.
            if (n_cnt >= i_cfg.total_windows) begin
                if (n_trig && tdiff(r_stream_end, n_seg) > min_sp) begin
                    emit    = 1'b1;
                    e_start = n_seg;
                    e_end   = r_stream_end;
                end
                n_trig  = 1'b0;
                n_pend  = 1'b0;
                n_sil   = '0;
                n_seg   = '0;
                n_clock = '0;
                n_cnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig   <= 1'b0;
            r_pend   <= 1'b0;
            r_sil    <= '0;
            r_seg    <= '0;
            r_clock  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_trig  <= n_trig;
            r_pend  <= n_pend;
            r_sil   <= n_sil;
            r_seg   <= n_seg;
            r_clock <= n_clock;
            r_cnt   <= n_cnt;
            if (o_pop) begin
                r_ovalid <= emit;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stream_end <= stream_end_c;
        if (o_pop && emit) begin
            r_ostart <= e_start;
            r_oend   <= e_end;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_seg_start_ms = OUT_BITS'(r_ostart);
    assign o_seg_end_ms   = OUT_BITS'(r_oend);

endmodule
`default_nettype wire

### src/speech_segment_merger.sv
// Speech segment merger: per-window speech probabilities in, timed segments out.
//
// The input channel (i_in_valid / o_in_stall) carries one item per window: a
// Q0.16 probability and a flag for a failed inference. The output channel
// (o_out_valid / i_out_stall) carries a segment's start and end in ms. A
// window gives zero or one segment. Both channels move an item at a clock edge
// with valid high and stall low.
// An accepted item is classified and written into a four-entry queue; the
// tracker pops it from the queue head, and its segment, if any, is written
// into the result register as the item is popped. One item per cycle is
// sustained while no result waits on a stalled receiver; the tracker's state
// update is combinational, with saturating time adders.
// While a result waits on a stalled receiver, the result register holds, the
// tracker stops, and once the queue holds four items o_in_stall rises.
// Reset (synchronous, active low) loads the register defaults, clears the
// segment state and the window clock, and empties the queue.
// Registers sit at byte address 4*index on the APB-style port; pready is
// always high. Write them only while no item is in flight.
`default_nettype none
module speech_segment_merger (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssm_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [15:0]                   i_prob,
    input  wire logic                          i_failed,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ssm_pkg::OUT_BITS-1:0]       o_seg_start_ms,
    output logic [ssm_pkg::OUT_BITS-1:0]       o_seg_end_ms
);
    import ssm_pkg::*;

    t_cfg   cfg;
    t_qstat qstat;
    t_class push_item;
    t_class head_item;
    logic   push;
    logic   pop;

    ssm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssm_front u_front (
        .i_in_valid (i_in_valid),
        .i_prob     (i_prob),
        .i_failed   (i_failed),
        .i_cfg      (cfg),
        .i_qstat    (qstat),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_item     (push_item)
    );

    ssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (qstat)
    );

    ssm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_item         (head_item),
        .i_qstat        (qstat),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_seg_start_ms (o_seg_start_ms),
        .o_seg_end_ms   (o_seg_end_ms)
    );

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.count <= Q_CW'(Q_DEPTH))
        else $error("queue count exceeds depth");

    // A stalled result keeps the tracker from draining the queue.
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !pop)
        else $error("tracker consumed an item while its result was stalled");

    // A new result only appears after the tracker consumed an item.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("result appeared without a consumed item");

endmodule
`default_nettype wire

### test/tb_speech_segment_merger.sv
// Self-checking testbench of the speech segment merger: directed and random windows.
`timescale 1ns / 1ps
module tb_speech_segment_merger;
    import ssm_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;

    typedef struct packed {
        logic [OUT_BITS-1:0] seg_start;
        logic [OUT_BITS-1:0] seg_stop;
    } t_seg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [15:0]          i_prob = '0;
    logic                 i_failed = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUT_BITS-1:0]  o_seg_start_ms;
    logic [OUT_BITS-1:0]  o_seg_end_ms;

    speech_segment_merger u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_prob         (i_prob),
        .i_failed       (i_failed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_seg_start_ms (o_seg_start_ms),
        .o_seg_end_ms   (o_seg_end_ms)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Tracker copy: register shadow and segment state.
    t_cfg                reg_shadow;
    logic                triggered;
    logic                silence_pending;
    t_time               silence_start;
    t_time               segment_start;
    t_time               clock_ms;
    logic [CNT_BITS-1:0] window_count;

    t_seg pending_segments[$];
    int   failures = 0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    function automatic logic [63:0] ms_add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > TIME_MAX) ? TIME_MAX : s;
    endfunction

    function automatic logic [63:0] ms_gap(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic void clear_tracker();
        triggered       = 1'b0;
        silence_pending = 1'b0;
        silence_start   = '0;
        segment_start   = '0;
        clock_ms        = '0;
        window_count    = '0;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_THRESHOLD:     reg_shadow.threshold      = value[15:0];
            REG_WINDOW_MS:     reg_shadow.window_ms      = value[9:0];
            REG_MIN_SILENCE:   reg_shadow.min_silence_ms = value[15:0];
            REG_MIN_SPEECH:    reg_shadow.min_speech_ms  = value[15:0];
            REG_SPEECH_PAD:    reg_shadow.speech_pad_ms  = value[15:0];
            REG_TOTAL_WINDOWS: reg_shadow.total_windows  = value[CNT_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
        case (idx)
            REG_THRESHOLD:     return 32'(reg_shadow.threshold);
            REG_WINDOW_MS:     return 32'(reg_shadow.window_ms);
            REG_MIN_SILENCE:   return 32'(reg_shadow.min_silence_ms);
            REG_MIN_SPEECH:    return 32'(reg_shadow.min_speech_ms);
            REG_SPEECH_PAD:    return 32'(reg_shadow.speech_pad_ms);
            REG_TOTAL_WINDOWS: return 32'(reg_shadow.total_windows);
            default:           return 32'd0;
        endcase
    endfunction

    // Advances the tracker by one window; returns 1 when the window emits a segment.
    function automatic bit track_window(input logic [15:0] prob, input logic failed,
                                        output t_seg seg);
        logic [63:0] stream_end;
        logic [63:0] w_start;
        logic [63:0] w_stop;
        logic [63:0] pad;
        logic [63:0] padded_start;
        logic [63:0] padded_stop;
        logic        loud;
        logic        near_thr;
        bit          hit;
        hit = 1'b0;
        seg = '0;
        pad = 64'(reg_shadow.speech_pad_ms);
        stream_end = 64'(reg_shadow.total_windows) * 64'(reg_shadow.window_ms);
        if (stream_end > TIME_MAX) begin
            stream_end = TIME_MAX;
        end
        w_start = 64'(clock_ms);
        w_stop  = ms_add_sat(w_start, 64'(reg_shadow.window_ms));
        loud     = !failed && (prob >= reg_shadow.threshold);
        // The lower threshold goes negative for small thresholds.
        near_thr = !failed &&
                   (int'(prob) >= int'(reg_shadow.threshold) - int'(LOW_OFFSET));

        if (loud) begin
            silence_pending = 1'b0;
        end
        if (near_thr && !triggered) begin
            triggered     = 1'b1;
            segment_start = w_start[TIME_BITS-1:0];
        end else if (!loud && triggered) begin
            if (!silence_pending) begin
                silence_pending = 1'b1;
                silence_start   = w_start[TIME_BITS-1:0];
            end
            if (ms_gap(w_stop, 64'(silence_start)) >= 64'(reg_shadow.min_silence_ms)) begin
                if (ms_gap(64'(silence_start), 64'(segment_start)) >
                    64'(reg_shadow.min_speech_ms)) begin
                    padded_start = (64'(segment_start) > pad) ? 64'(segment_start) - pad
                                                              : 64'd0;
                    padded_stop  = ms_add_sat(64'(silence_start), pad);
                    if (padded_stop > stream_end) begin
                        padded_stop = stream_end;
                    end
                    seg.seg_start = padded_start[OUT_BITS-1:0];
                    seg.seg_stop  = padded_stop[OUT_BITS-1:0];
                    hit = 1'b1;
                end
                triggered       = 1'b0;
                silence_pending = 1'b0;
                silence_start   = '0;
                segment_start   = '0;
            end
        end

        clock_ms     = w_stop[TIME_BITS-1:0];
        window_count = window_count + 1'b1;
        // Last window: an open segment is flushed unpadded, then the stream restarts.
        if (window_count >= reg_shadow.total_windows) begin
            if (triggered &&
                ms_gap(stream_end, 64'(segment_start)) > 64'(reg_shadow.min_speech_ms)) begin
                seg.seg_start = segment_start[OUT_BITS-1:0];
                seg.seg_stop  = stream_end[OUT_BITS-1:0];
                hit = 1'b1;
            end
            clear_tracker();
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        t_seg want;
        t_seg got;
        bit   in_acc;
        bit   out_acc;
        in_acc  = i_rst_n && i_in_valid && !o_in_stall;
        out_acc = i_rst_n && o_out_valid && !i_out_stall;
        if (in_acc) begin
            if (track_window(i_prob, i_failed, want)) begin
                pending_segments = {pending_segments, want};
            end
        end
        if (out_acc) begin
            got.seg_start = o_seg_start_ms;
            got.seg_stop  = o_seg_end_ms;
            if (pending_segments.size() == 0) begin
                note_failure($sformatf("segment %0d..%0d with none expected",
                                       got.seg_start, got.seg_stop));
            end else begin
                want = pending_segments.pop_front();
                if (got.seg_start !== want.seg_start) begin
                    note_failure($sformatf("seg_start_ms expected %0d got %0d",
                                           want.seg_start, got.seg_start));
                end
                if (got.seg_stop !== want.seg_stop) begin
                    note_failure($sformatf("seg_end_ms expected %0d got %0d",
                                           want.seg_stop, got.seg_stop));
                end
            end
        end
        if (in_acc || out_acc) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_window(input logic [15:0] p, input logic f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_prob     <= p;
        i_failed   <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Lets every item in flight finish before the registers are touched.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_check(input logic [2:0] idx);
        logic [31:0] want;
        want = shadow_reg(idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            note_failure($sformatf("register %0d expected %0d got %0d", idx, want, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [9:0] win,
                              input logic [15:0] sil, input logic [15:0] sp,
                              input logic [15:0] pad, input logic [23:0] total);
        wait_idle();
        write_reg(REG_THRESHOLD, 32'(thr));
        write_reg(REG_WINDOW_MS, 32'(win));
        write_reg(REG_MIN_SILENCE, 32'(sil));
        write_reg(REG_MIN_SPEECH, 32'(sp));
        write_reg(REG_SPEECH_PAD, 32'(pad));
        write_reg(REG_TOTAL_WINDOWS, 32'(total));
    endtask

    task automatic check_all_regs();
        read_check(REG_THRESHOLD);
        read_check(REG_WINDOW_MS);
        read_check(REG_MIN_SILENCE);
        read_check(REG_MIN_SPEECH);
        read_check(REG_SPEECH_PAD);
        read_check(REG_TOTAL_WINDOWS);
    endtask

    task automatic test_register_access();
        check_all_regs();
        set_config(16'd1234, 10'd517, 16'd4321, 16'd777, 16'd99, 24'hABCDEF);
        check_all_regs();
    endtask

    // A segment opens at exactly the lower threshold, a silence is cancelled, a
    // padded close clamps at zero, and a second segment is flushed at stream end.
    task automatic test_segment_close();
        set_config(16'd32768, 10'd10, 16'd20, 16'd30, 16'd15, 24'd12);
        send_window(16'd0, 1'b0);
        send_window(16'd22938, 1'b0);
        send_window(16'd65535, 1'b0);
        send_window(16'd65535, 1'b1);
        send_window(16'd40000, 1'b0);
        send_window(16'd22937, 1'b0);
        send_window(16'd0, 1'b0);
        repeat (5) send_window(16'd65535, 1'b0);
    endtask

    // Negative lower threshold, a stream where every window is the last, and a
    // window length of zero so the clock stands still.
    task automatic test_zero_window_low_threshold();
        set_config(16'd5000, 10'd25, 16'd0, 16'd0, 16'd0, 24'd0);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b1);
        send_window(16'd65535, 1'b0);
        set_config(16'd5000, 10'd0, 16'd0, 16'd0, 16'd0, 24'd3);
        send_window(16'd0, 1'b0);
        send_window(16'd0, 1'b1);
        send_window(16'd0, 1'b0);
    endtask

    // The segment closes on the last window; no flush may follow it.
    task automatic test_close_on_last_window();
        set_config(16'd32768, 10'd10, 16'd10, 16'd5, 16'd0, 24'd4);
        repeat (3) send_window(16'd65535, 1'b0);
        send_window(16'd0, 1'b0);
    endtask

    task automatic draw_window(input int kind, output logic [15:0] p, output logic f);
        int thr;
        thr = reg_shadow.threshold;
        f = 1'b0;
        case (kind)
            0, 1, 2, 3: p = 16'($urandom_range(65535, thr));
            4, 5, 6: begin
                if (thr > LOW_OFFSET) begin
                    p = 16'($urandom_range(thr - LOW_OFFSET - 1, 0));
                end else begin
                    // Nothing that succeeds is quiet here, so the window fails.
                    p = 16'($urandom_range(65535));
                    f = 1'b1;
                end
            end
            7: p = 16'($urandom_range((thr == 0) ? 0 : thr - 1,
                                      (thr > LOW_OFFSET) ? thr - LOW_OFFSET : 0));
            8: begin
                p = 16'($urandom_range(65535));
                f = 1'b1;
            end
            default: begin
                p = 16'($urandom_range(65535));
                f = ($urandom_range(7) == 0);
            end
        endcase
    endtask

    // Runs of speech, silence and the band between, with some failed and noisy items.
    task automatic random_windows(input int count);
        int          sent;
        int          run;
        int          kind;
        int          i;
        logic [15:0] p;
        logic        f;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(9);
            run  = $urandom_range(8, 1);
            for (i = 0; i < run && sent < count; i++) begin
                draw_window(kind, p, f);
                send_window(p, f);
                sent++;
            end
        end
    endtask

    task automatic random_config();
        logic [15:0] thr;
        logic [9:0]  win;
        logic [23:0] total;
        thr = 16'($urandom_range(65535));
        if ($urandom_range(4) == 0) begin
            thr = 16'($urandom_range(LOW_OFFSET));
        end
        win = 10'($urandom_range(50, 1));
        if ($urandom_range(3) == 0) begin
            total = 24'($urandom_range(24'hFFFFFF, 1000));
        end else begin
            total = 24'($urandom_range(80, 5));
        end
        set_config(thr, win, 16'(win * $urandom_range(4)), 16'(win * $urandom_range(6)),
                   16'($urandom_range(200)), total);
    endtask

    task automatic test_random_streams();
        int mode;
        int k;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 13;
                    recv_idle_pct = 58;
                end
                1: begin
                    send_idle_pct = 58;
                    recv_idle_pct = 13;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (k = 0; k < 3; k++) begin
                if (mode == 0 && k == 0) begin
                    set_config(16'hFFFF, 10'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
                end else if (mode == 1 && k == 0) begin
                    set_config(16'd0, 10'd1, 16'd0, 16'd0, 16'd0, 24'd1);
                end else begin
                    random_config();
                end
                random_windows(50);
            end
        end
    endtask

    initial begin
        reg_shadow = '{threshold: RST_THRESHOLD, window_ms: RST_WINDOW_MS,
                       min_silence_ms: RST_MIN_SILENCE, min_speech_ms: RST_MIN_SPEECH,
                       speech_pad_ms: RST_SPEECH_PAD, total_windows: RST_TOTAL_WINDOWS};
        clear_tracker();
        send_idle_pct = 13;
        recv_idle_pct = 58;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_segment_close();
        test_zero_window_low_threshold();
        test_close_on_last_window();
        test_random_streams();
        wait_idle();
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
